>>> rtl/mandelbrot_escape_time_pixel_top_macros.svh
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_MACROS_SVH

// Same-cycle implication on clk, off while in reset.
`define MEP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, off while in reset.
`define MEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mep_pkg.sv
`timescale 1ns / 1ps

package mep_pkg;

    localparam int COORD_BITS = 12;         // coordinate bits actually used
    localparam int PIX_W      = 12;
    localparam int Q_W        = 32;         // signed Q6.26
    localparam int UQ_W       = 31;         // unsigned Q5.26
    localparam int QF         = 26;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 64;

    localparam int MASK_BITS = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic [UQ_W-1:0]          uq_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEW_SCALE  = 3'd0,
        CFG_OFFSET_REAL = 3'd1,
        CFG_OFFSET_IMAG = 3'd2,
        CFG_INV_WIDTH   = 3'd3,
        CFG_INV_HEIGHT  = 3'd4,
        CFG_ASPECT      = 3'd5,
        CFG_ITER_LIMIT  = 3'd6
    } cfg_reg_t;

    localparam pix_t PIX_MASK = PIX_W'((33'd1 << MASK_BITS) - 33'd1);

    localparam q_t     VIEW_SCALE_RST  = 32'sd67108864;
    localparam q_t     OFFSET_RST      = 32'sd0;
    localparam uq_t    INV_DIM_RST     = 31'd65536;
    localparam uq_t    ASPECT_RST      = 31'd67108864;
    localparam count_t ITER_LIMIT_RST  = 16'd256;

    localparam prod_t HALF_Q = 64'sd33554432;            // 0.5 in Q6.26
    localparam logic [PROD_W-1:0] BOUND_Q = 64'd1 << 54; // 4.0 in Q12.52
    localparam prod_t Q_MAX  = 64'sd2147483647;
    localparam prod_t Q_MIN  = -64'sd2147483648;

    function automatic q_t sat32(input prod_t v);
        q_t r;
        if (v > Q_MAX)
        begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        else if (v < Q_MIN)
        begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/mandelbrot_escape_time_pixel_top.sv
`timescale 1ns / 1ps

// Mandelbrot escape-time pixel engine. A pixel (x, y) is taken when pixel_valid is high and
// pixel_stall low; the block then stays stalled until its result is in the output register.
// All multiplications go through one 33x33 signed multiplier with a registered product: the
// pixel is mapped to c by a sequence of products, and each iteration of z = z^2 + c runs the
// z*z products, the |z|^2 check and the new z in turn. A nonzero count is then divided by the
// limit for the shade in a shift-subtract loop that forms a 16-bit quotient. The result
// register frees the input side while a result waits on result_stall. Configuration writes
// are always taken (cfg_ready high) and must only happen while no pixel is in flight.
module mandelbrot_escape_time_pixel_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  mep_pkg::pix_t                     pixel_x,
    input  mep_pkg::pix_t                     pixel_y,
    output logic                              result_valid,
    input  logic                              result_stall,
    output mep_pkg::count_t                   escape_count,
    output mep_pkg::count_t                   shade,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mep_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mep_pkg::*;

    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_W     = $clog2(DIV_STEPS);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MAP  = 8'b0000_0010,
        ST_SQX  = 8'b0000_0100,
        ST_SQY  = 8'b0000_1000,
        ST_CHK  = 8'b0001_0000,
        ST_NXY  = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    // mapping sequence: even steps issue a product, odd steps consume it
    typedef enum logic [3:0] {
        MS_PX = 4'd0,
        MS_T1 = 4'd1,
        MS_AS = 4'd2,
        MS_T2 = 4'd3,
        MS_SX = 4'd4,
        MS_CX = 4'd5,
        MS_PY = 4'd6,
        MS_T3 = 4'd7,
        MS_SY = 4'd8,
        MS_CY = 4'd9
    } map_step_t;

    // configuration
    q_t     view_scale_reg;
    q_t     offset_real_reg;
    q_t     offset_imag_reg;
    uq_t    inv_width_reg;
    uq_t    inv_height_reg;
    uq_t    aspect_reg;
    count_t iter_limit_reg;

    // control
    state_t            state_reg, state_next;
    map_step_t         step_reg, step_next;
    logic [DIV_W-1:0]  div_cnt_reg, div_cnt_next;
    count_t            count_reg, count_next;
    logic              first_reg, first_next;
    logic              result_valid_reg, result_valid_next;

    // datapath
    pix_t   px_reg, px_next;
    pix_t   py_reg, py_next;
    prod_t  prod_reg;
    q_t     t_reg, t_next;
    q_t     cx_reg, cx_next;
    q_t     cy_reg, cy_next;
    q_t     nx_reg, nx_next;
    q_t     ny_reg, ny_next;
    prod_t  xx_reg, xx_next;
    prod_t  diff_reg, diff_next;
    count_t rem_reg, rem_next;
    count_t quot_reg, quot_next;
    count_t escape_count_reg, escape_count_next;
    count_t shade_reg, shade_next;

    // shared multiplier
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] mul_full;

    logic [PROD_W-1:0] sq_sum;
    logic              escape_hit;
    logic [CNT_W:0]    count_inc;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_sub;
    logic              rem_take;
    q_t                cy_val;

    assign pixel_stall  = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign escape_count = escape_count_reg;
    assign shade        = shade_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_scale_reg  <= VIEW_SCALE_RST;
            offset_real_reg <= OFFSET_RST;
            offset_imag_reg <= OFFSET_RST;
            inv_width_reg   <= INV_DIM_RST;
            inv_height_reg  <= INV_DIM_RST;
            aspect_reg      <= ASPECT_RST;
            iter_limit_reg  <= ITER_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_VIEW_SCALE:  view_scale_reg  <= cfg_data[Q_W-1:0];
                CFG_OFFSET_REAL: offset_real_reg <= cfg_data[Q_W-1:0];
                CFG_OFFSET_IMAG: offset_imag_reg <= cfg_data[Q_W-1:0];
                CFG_INV_WIDTH:   inv_width_reg   <= cfg_data[UQ_W-1:0];
                CFG_INV_HEIGHT:  inv_height_reg  <= cfg_data[UQ_W-1:0];
                CFG_ASPECT:      aspect_reg      <= cfg_data[UQ_W-1:0];
                CFG_ITER_LIMIT:  iter_limit_reg  <= cfg_data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MAP:
            begin
                case (step_reg)
                    MS_PX:
                    begin
                        mul_a = MUL_W'(px_reg);
                        mul_b = MUL_W'(inv_width_reg);
                    end
                    MS_AS:
                    begin
                        mul_a = MUL_W'(t_reg);
                        mul_b = MUL_W'(aspect_reg);
                    end
                    MS_SX, MS_SY:
                    begin
                        mul_a = MUL_W'(t_reg);
                        mul_b = MUL_W'(view_scale_reg);
                    end
                    MS_PY:
                    begin
                        mul_a = MUL_W'(py_reg);
                        mul_b = MUL_W'(inv_height_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SQX:
            begin
                mul_a = MUL_W'(nx_reg);
                mul_b = MUL_W'(nx_reg);
            end
            ST_SQY:
            begin
                mul_a = MUL_W'(ny_reg);
                mul_b = MUL_W'(ny_reg);
            end
            ST_CHK:
            begin
                mul_a = MUL_W'(nx_reg);
                mul_b = MUL_W'(ny_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // both terms are squares here, so the sum is at most 2^63
    assign sq_sum     = xx_reg + prod_reg;
    assign escape_hit = (sq_sum >= BOUND_Q);
    assign count_inc  = {1'b0, count_reg} + {{CNT_W{1'b0}}, !first_reg};

    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_sub  = rem_sh - {1'b0, iter_limit_reg};
    assign rem_take = (rem_sh >= {1'b0, iter_limit_reg});

    assign cy_val = sat32((prod_reg >>> QF) + PROD_W'(offset_imag_reg));

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        div_cnt_next      = div_cnt_reg;
        count_next        = count_reg;
        first_next        = first_reg;
        result_valid_next = result_valid_reg && result_stall;
        px_next           = px_reg;
        py_next           = py_reg;
        t_next            = t_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        nx_next           = nx_reg;
        ny_next           = ny_reg;
        xx_next           = xx_reg;
        diff_next         = diff_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;
        escape_count_next = escape_count_reg;
        shade_next        = shade_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    px_next    = pixel_x & PIX_MASK;
                    py_next    = pixel_y & PIX_MASK;
                    step_next  = MS_PX;
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                step_next = map_step_t'(step_reg + 4'd1);
                case (step_reg)
                    MS_T1: t_next  = sat32(prod_reg);
                    MS_T2: t_next  = sat32((prod_reg >>> QF) - HALF_Q);
                    MS_CX: cx_next = sat32((prod_reg >>> QF) + PROD_W'(offset_real_reg));
                    MS_T3: t_next  = sat32(prod_reg - HALF_Q);
                    MS_CY:
                    begin
                        cy_next    = cy_val;
                        nx_next    = cx_reg;
                        ny_next    = cy_val;
                        count_next = '0;
                        first_next = 1'b1;
                        if (iter_limit_reg == '0)
                        begin
                            quot_next  = '0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SQX;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SQX:
            begin
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                xx_next    = prod_reg;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                // z = c is not checked; every later z is
                diff_next = xx_reg - prod_reg;
                if (!first_reg && escape_hit)
                begin
                    if (count_reg == '0)
                    begin
                        quot_next  = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rem_next     = count_reg;
                        quot_next    = '0;
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                end
                else if (count_inc >= {1'b0, iter_limit_reg})
                begin
                    // bailout: report zero
                    count_next = '0;
                    quot_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    count_next = count_inc[CNT_W-1:0];
                    first_next = 1'b0;
                    state_next = ST_NXY;
                end
            end
            ST_NXY:
            begin
                nx_next    = sat32((diff_reg >>> QF) + PROD_W'(cx_reg));
                ny_next    = sat32((prod_reg >>> (QF - 1)) + PROD_W'(cy_reg));
                state_next = ST_SQX;
            end
            ST_DIV:
            begin
                rem_next     = rem_take ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                quot_next    = {quot_reg[CNT_W-2:0], rem_take};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    escape_count_next = count_reg;
                    shade_next        = quot_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= MS_PX;
            div_cnt_reg      <= '0;
            count_reg        <= '0;
            first_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            div_cnt_reg      <= div_cnt_next;
            count_reg        <= count_next;
            first_reg        <= first_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg         <= mul_full[PROD_W-1:0];
        px_reg           <= px_next;
        py_reg           <= py_next;
        t_reg            <= t_next;
        cx_reg           <= cx_next;
        cy_reg           <= cy_next;
        nx_reg           <= nx_next;
        ny_reg           <= ny_next;
        xx_reg           <= xx_next;
        diff_reg         <= diff_next;
        rem_reg          <= rem_next;
        quot_reg         <= quot_next;
        escape_count_reg <= escape_count_next;
        shade_reg        <= shade_next;
    end

endmodule

>>> rtl/mep_checker.sv
`timescale 1ns / 1ps

`include "mandelbrot_escape_time_pixel_top_macros.svh"

module mep_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            pixel_valid,
    input logic            pixel_stall,
    input logic            result_valid,
    input logic            result_stall,
    input mep_pkg::count_t escape_count,
    input mep_pkg::count_t shade
);

    // one pixel at a time: busy right after a beat
    `MEP_ASSERT_NEXT(a_busy_after_beat, pixel_valid && !pixel_stall, pixel_stall, "no stall after pixel beat")

    // a new result only comes out of a busy engine
    `MEP_ASSERT_SAME(a_result_from_work, $rose(result_valid), $past(pixel_stall), "result without work")

    // bailout or early escape gives zero shade
    `MEP_ASSERT_SAME(a_zero_shade, result_valid && (escape_count == '0), shade == '0, "shade without count")

    `MEP_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(escape_count) && $stable(shade), "stalled result changed")

endmodule

bind mandelbrot_escape_time_pixel_top mep_checker u_mep_checker (.*);
